// ===== rtl/core/b64d_pkg.sv =====
// Shared types, constants and the character map of the base64 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam logic [15:0] CAPACITY_RESET = 16'd4096;
  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_SLASH = 8'd47;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_DONE     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
    logic            eot;
  } job_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    status_t     status;
    logic [15:0] byte_total;
    logic        run_last;
  } result_t;

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == CHAR_PLUS) begin
      r = 7'd62;
    end else if (c == CHAR_SLASH) begin
      r = 7'd63;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64d_fifo.sv =====
// Small register queue used between the decoder stages and at the result side.
`timescale 1ns / 1ps
`default_nettype none
module b64d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_front.sv =====
// Front stage: maps characters, gathers sextets and forms byte jobs.
`timescale 1ns / 1ps
`default_nettype none
module b64d_front
  import b64d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_text,
  output logic            job_push,
  output job_t            job,
  input  wire logic       job_full
);

  logic [17:0] store_r, store_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [6:0]  mapped;
  logic [23:0] grp;
  logic        accept;

  assign full   = job_full;
  assign accept = push && !job_full;
  assign mapped = map_char(in_char_code);
  assign grp    = {store_r, mapped[5:0]};

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    job       = '0;
    job.eot   = in_end_of_text;
    job_push  = 1'b0;
    if (!mapped[6]) begin
      if (count_r == 2'd3) begin
        job.bytes = {grp[7:0], grp[15:8], grp[23:16]};
        job.n     = 2'd3;
        store_nxt = '0;
        count_nxt = 2'd0;
      end else begin
        store_nxt = {store_r[11:0], mapped[5:0]};
        count_nxt = count_r + 2'd1;
      end
    end
    if (in_end_of_text) begin
      if (count_nxt == 2'd2) begin
        job.bytes[0] = store_nxt[11:4];
        job.n        = 2'd1;
      end else if (count_nxt == 2'd3) begin
        job.bytes[0] = store_nxt[17:10];
        job.bytes[1] = store_nxt[9:2];
        job.n        = 2'd2;
      end
      store_nxt = '0;
      count_nxt = 2'd0;
    end
    job_push = accept && (in_end_of_text || (job.n != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      store_r <= store_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/b64d_back.sv =====
// Back stage: up to one result per cycle, stalling on an empty job queue or full result queue; capacity check, totals.
`timescale 1ns / 1ps
`default_nettype none
module b64d_back
  import b64d_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_output_capacity,
  input  job_t             job,
  input  wire logic        job_empty,
  output logic             job_pop,
  output logic             res_push,
  output result_t          res,
  input  wire logic        res_full
);

  localparam int W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [15:0]           cap_r;
  logic [1:0]            idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt, done_inc;
  logic                  ovf_r, ovf_nxt;
  logic [W-1:0]          done_ext, inc_ext, inc_wrap_ext;
  logic                  fits, is_data, job_end, step;
  logic [7:0]            byte_sel;

  assign cfg_ready    = 1'b1;
  assign step         = !job_empty && !res_full;
  assign done_ext     = W'(done_r);
  assign inc_ext      = done_ext + W'(1);
  assign fits         = inc_ext < W'(cap_r);
  assign done_inc     = COUNT_BITS'(inc_ext);
  assign inc_wrap_ext = W'(done_inc);
  assign is_data      = idx_r < job.n;

  always_comb begin
    case (idx_r)
      2'd0:    byte_sel = job.bytes[0];
      2'd1:    byte_sel = job.bytes[1];
      2'd2:    byte_sel = job.bytes[2];
      default: byte_sel = '0;
    endcase
  end

  always_comb begin
    res      = '0;
    res_push = 1'b0;
    job_pop  = 1'b0;
    idx_nxt  = idx_r;
    done_nxt = done_r;
    ovf_nxt  = ovf_r;
    job_end  = is_data ? ((idx_r == job.n - 2'd1) && !job.eot) : 1'b1;
    if (step) begin
      if (is_data) begin
        if (!ovf_r) begin
          res_push = 1'b1;
          if (fits) begin
            res.out_byte   = byte_sel;
            res.status     = ST_DATA;
            res.byte_total = inc_wrap_ext[15:0];
            res.run_last   = job_end;
            done_nxt       = done_inc;
          end else begin
            res.status     = ST_OVERFLOW;
            res.byte_total = done_ext[15:0];
            res.run_last   = !job.eot;
            ovf_nxt        = 1'b1;
          end
        end
      end else begin
        res_push       = 1'b1;
        res.status     = ovf_r ? ST_OVERFLOW : ST_DONE;
        res.byte_total = done_ext[15:0];
        res.run_last   = 1'b1;
        done_nxt       = '0;
        ovf_nxt        = 1'b0;
      end
      if (job_end) begin
        job_pop = 1'b1;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAPACITY_RESET;
      idx_r  <= '0;
      done_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_output_capacity;
      end
      idx_r  <= idx_nxt;
      done_r <= done_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !job_empty |-> idx_r <= job.n)
    else $error("byte index ran past the job");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res.status == ST_DONE |-> res.run_last)
    else $error("end result not marked last");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_data |=> done_r == '0 && !ovf_r)
    else $error("string state not cleared after end");

  a_no_data_after_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && ovf_r |-> res.status != ST_DATA)
    else $error("data byte emitted after overflow");

endmodule
`default_nettype wire

// ===== rtl/core/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
// The front stage takes one character per cycle whenever full is low and turns
// each completed sextet group into a job of up to three bytes; a two-entry job
// queue separates it from the back stage, which produces at most one result per
// cycle (data byte, overflow or end result) into a two-entry result queue, and
// stalls while the job queue is empty or the result queue is full. Input runs at
// one character per cycle while full is low; sustained speed is set by the back
// stage's one result per byte, so a four-character group needs three results.
// The capacity register is written through cfg_valid with cfg_ready always
// high and applies from the next item.
`timescale 1ns / 1ps
`default_nettype none
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_text,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_status,
  output logic [15:0]      out_byte_total,
  output logic             out_run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_output_capacity
);

  job_t                     job_in, job_out;
  logic                     job_push, job_full, job_pop, job_empty;
  logic [$bits(job_t)-1:0]  job_rdata;
  result_t                  res_in, res_out;
  logic                     res_push, res_full;
  logic [$bits(result_t)-1:0] res_rdata;

  b64d_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .job_push       (job_push),
    .job            (job_in),
    .job_full       (job_full)
  );

  b64d_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_out = job_t'(job_rdata);

  b64d_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_output_capacity (cfg_output_capacity),
    .job                 (job_out),
    .job_empty           (job_empty),
    .job_pop             (job_pop),
    .res_push            (res_push),
    .res                 (res_in),
    .res_full            (res_full)
  );

  b64d_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out        = result_t'(res_rdata);
  assign out_byte       = res_out.out_byte;
  assign out_status     = res_out.status;
  assign out_byte_total = res_out.byte_total;
  assign out_run_last   = res_out.run_last;

endmodule
`default_nettype wire
